// ----- sv/roi_pkg.sv -----
// roi_pkg: shared widths, codes and record types for the ray/obstacle intersection block
// used by roi_front, roi_queue, roi_back and ray_obstacle_intersection
// no dependencies
package roi_pkg;

  // fixed point formats
  localparam int DIR_FRAC_BITS = 14;
  localparam int DIST_W = 16;
  localparam logic [DIST_W-1:0] RANGE_RESET = 16'd51200;

  // front arithmetic widths
  localparam int W1 = 17;                        // coordinate differences
  localparam int PW = 34;                        // products of two differences
  localparam int W3 = 35;                        // sums of products
  localparam int DEN_W = W3;
  localparam int DIV_STEPS = DIST_W;
  localparam int NUM_W = (W3 + DIR_FRAC_BITS > DEN_W + DIV_STEPS) ?
                         W3 + DIR_FRAC_BITS : DEN_W + DIV_STEPS;
  localparam int H_W = (W3 - DIR_FRAC_BITS > 17) ? W3 - DIR_FRAC_BITS : 17;
  localparam int SQ_W = 2 * H_W;
  localparam int ROOT_STEPS = H_W;
  localparam int T_W = H_W + 3;
  localparam logic signed [W3-1:0] H_ROUND = W3'(1) << (DIR_FRAC_BITS - 1);

  // front pipeline and job queue
  localparam int F_STAGES = 6;
  localparam int FC_W = $clog2(F_STAGES + 1);
  localparam int JQ_DEPTH = 16;
  localparam int JQ_AW = $clog2(JQ_DEPTH);
  localparam int JQ_CW = JQ_AW + 1;
  localparam int JQ_SW = JQ_CW + 1;

  // back pipeline and result queue
  localparam int B_STAGES = (ROOT_STEPS > DIV_STEPS) ? ROOT_STEPS : DIV_STEPS;
  localparam int BC_W = $clog2(B_STAGES + 1);
  localparam int OQ_DEPTH = 2 ** $clog2(B_STAGES + 4);
  localparam int OQ_AW = $clog2(OQ_DEPTH);
  localparam int OQ_CW = OQ_AW + 1;
  localparam int OQ_SW = OQ_CW + 1;

  typedef enum logic {
    KIND_SEGMENT = 1'b0,
    KIND_CIRCLE  = 1'b1
  } kind_t;

  // classified work handed from front to back
  typedef struct packed {
    kind_t                   kind;
    logic                    miss;
    logic [NUM_W-1:0]        num;
    logic [DEN_W-1:0]        den;
    logic [SQ_W-1:0]         q;
    logic signed [H_W-1:0]   h;
  } job_t;

  // one stage of the shared divide / square root pipeline
  typedef struct packed {
    kind_t                   kind;
    logic                    miss;
    logic [NUM_W-1:0]        num;
    logic [DEN_W-1:0]        den;
    logic [DIV_STEPS-1:0]    quo;
    logic [SQ_W-1:0]         v;
    logic [SQ_W-1:0]         res;
    logic signed [H_W-1:0]   h;
  } stage_t;

  typedef struct packed {
    logic [JQ_CW-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic [BC_W-1:0]  inflight;
    logic [OQ_CW-1:0] out_count;
  } b_stat_t;

endpackage

// ----- sv/roi_front.sv -----
// roi_front: accepts words, runs the products and sign tests, emits one job per word
// depends on roi_pkg
module roi_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          kind,
  input  logic signed [15:0]            ray_x,
  input  logic signed [15:0]            ray_y,
  input  logic signed [15:0]            dir_cos,
  input  logic signed [15:0]            dir_sin,
  input  logic signed [15:0]            point_a_x,
  input  logic signed [15:0]            point_a_y,
  input  logic signed [15:0]            point_b_x,
  input  logic signed [15:0]            point_b_y,
  input  logic [14:0]                   radius,
  input  logic [roi_pkg::DIST_W-1:0]    max_range,
  input  roi_pkg::q_stat_t              q_stat,
  output logic                          job_valid,
  output roi_pkg::job_t                 job,
  output logic [roi_pkg::FC_W-1:0]      inflight
);

  logic accept;
  logic bbox_rej;
  logic [roi_pkg::JQ_SW-1:0] credit_used;

  // stage 1: differences and bounding box reject
  logic                             s1_valid, s1_bbox;
  roi_pkg::kind_t                   s1_kind;
  logic signed [15:0]               s1_c, s1_s;
  logic signed [roi_pkg::W1-1:0]    s1_dyab, s1_dxab, s1_dyar, s1_dxar;
  logic [14:0]                      s1_r;

  // stage 2: products
  logic                             s2_valid, s2_bbox;
  roi_pkg::kind_t                   s2_kind;
  logic signed [roi_pkg::PW-1:0]    s2_den1, s2_den2, s2_tn1, s2_tn2, s2_un1, s2_un2;
  logic signed [roi_pkg::PW-1:0]    s2_sqx, s2_sqy, s2_hx, s2_hy;
  logic [29:0]                      s2_r2;
  logic [16:0]                      s2_reach;

  // stage 3: sums
  logic                             s3_valid, s3_bbox;
  roi_pkg::kind_t                   s3_kind;
  logic signed [roi_pkg::W3-1:0]    s3_den, s3_tn, s3_un, s3_f2, s3_hraw;
  logic [33:0]                      s3_reach2;
  logic [29:0]                      s3_r2;

  // stage 4: sign normalize, rounding, reach test
  logic                             den_neg;
  logic signed [roi_pkg::W3-1:0]    den_a, tn_n, un_n, hsum;
  logic                             seg_miss4, circ_miss4;
  logic                             s4_valid, s4_seg_miss, s4_circ_miss;
  roi_pkg::kind_t                   s4_kind;
  logic [roi_pkg::DEN_W-1:0]        s4_den;
  logic signed [roi_pkg::W3-1:0]    s4_un, s4_f2;
  logic signed [roi_pkg::H_W-1:0]   s4_h;
  logic [29:0]                      s4_r2;

  // stage 5: range product and square of h
  logic                             s5_valid, s5_seg_miss, s5_circ_miss;
  roi_pkg::kind_t                   s5_kind;
  logic [roi_pkg::NUM_W-1:0]        s5_dr, s5_num;
  logic [roi_pkg::DEN_W-1:0]        s5_den;
  logic [roi_pkg::SQ_W-1:0]         s5_hh;
  logic signed [roi_pkg::W3:0]      s5_rem;
  logic signed [roi_pkg::H_W-1:0]   s5_h;

  // stage 6 inputs
  logic signed [roi_pkg::SQ_W:0]    q_full;
  logic                             seg_miss6, circ_miss6;
  logic [roi_pkg::FC_W-1:0]         fcnt;

  // credit: queued jobs plus words still in this pipeline
  assign credit_used = roi_pkg::JQ_SW'(q_stat.count) + roi_pkg::JQ_SW'(fcnt);
  assign full = credit_used >= roi_pkg::JQ_SW'(roi_pkg::JQ_DEPTH);
  assign accept = push && !full;
  assign inflight = fcnt;

  // ray moving away from the box on either axis
  assign bbox_rej =
    (dir_cos > 16'sd0 && ray_x > point_a_x && ray_x > point_b_x) ||
    (dir_cos < 16'sd0 && ray_x < point_a_x && ray_x < point_b_x) ||
    (dir_sin > 16'sd0 && ray_y > point_a_y && ray_y > point_b_y) ||
    (dir_sin < 16'sd0 && ray_y < point_a_y && ray_y < point_b_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      job_valid <= 1'b0;
      fcnt <= '0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      job_valid <= s5_valid;
      fcnt <= fcnt + roi_pkg::FC_W'(accept) - roi_pkg::FC_W'(job_valid);
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    s1_kind <= roi_pkg::kind_t'(kind);
    s1_bbox <= bbox_rej;
    s1_c <= dir_cos;
    s1_s <= dir_sin;
    s1_dyab <= roi_pkg::W1'(point_a_y) - roi_pkg::W1'(point_b_y);
    s1_dxab <= roi_pkg::W1'(point_a_x) - roi_pkg::W1'(point_b_x);
    s1_dyar <= roi_pkg::W1'(point_a_y) - roi_pkg::W1'(ray_y);
    s1_dxar <= roi_pkg::W1'(point_a_x) - roi_pkg::W1'(ray_x);
    s1_r <= radius;
  end

  // stage 2
  always_ff @(posedge clk) begin
    s2_kind <= s1_kind;
    s2_bbox <= s1_bbox;
    s2_den1 <= roi_pkg::PW'(s1_dyab) * roi_pkg::PW'(s1_c);
    s2_den2 <= roi_pkg::PW'(s1_dxab) * roi_pkg::PW'(s1_s);
    s2_tn1 <= roi_pkg::PW'(s1_dyar) * roi_pkg::PW'(s1_c);
    s2_tn2 <= roi_pkg::PW'(s1_dxar) * roi_pkg::PW'(s1_s);
    s2_un1 <= roi_pkg::PW'(s1_dyab) * roi_pkg::PW'(s1_dxar);
    s2_un2 <= roi_pkg::PW'(s1_dxab) * roi_pkg::PW'(s1_dyar);
    s2_sqx <= roi_pkg::PW'(s1_dxar) * roi_pkg::PW'(s1_dxar);
    s2_sqy <= roi_pkg::PW'(s1_dyar) * roi_pkg::PW'(s1_dyar);
    s2_hx <= roi_pkg::PW'(s1_dxar) * roi_pkg::PW'(s1_c);
    s2_hy <= roi_pkg::PW'(s1_dyar) * roi_pkg::PW'(s1_s);
    s2_r2 <= 30'(s1_r) * 30'(s1_r);
    s2_reach <= 17'(max_range) + 17'(s1_r);
  end

  // stage 3
  always_ff @(posedge clk) begin
    s3_kind <= s2_kind;
    s3_bbox <= s2_bbox;
    s3_den <= roi_pkg::W3'(s2_den1) - roi_pkg::W3'(s2_den2);
    s3_tn <= roi_pkg::W3'(s2_tn1) - roi_pkg::W3'(s2_tn2);
    s3_un <= roi_pkg::W3'(s2_un1) - roi_pkg::W3'(s2_un2);
    s3_f2 <= roi_pkg::W3'(s2_sqx) + roi_pkg::W3'(s2_sqy);
    s3_hraw <= -(roi_pkg::W3'(s2_hx) + roi_pkg::W3'(s2_hy));
    s3_reach2 <= 34'(s2_reach) * 34'(s2_reach);
    s3_r2 <= s2_r2;
  end

  // stage 4 logic: make den positive, round h half up
  always_comb begin
    den_neg = s3_den < 0;
    den_a = den_neg ? -s3_den : s3_den;
    tn_n = den_neg ? -s3_tn : s3_tn;
    un_n = den_neg ? -s3_un : s3_un;
    hsum = s3_hraw + roi_pkg::H_ROUND;
    seg_miss4 = s3_bbox || (max_range == '0) || (s3_den == '0) ||
                (tn_n < 0) || (tn_n > den_a) || (un_n < 0);
    circ_miss4 = s3_f2 > $signed({1'b0, s3_reach2});
  end

  always_ff @(posedge clk) begin
    s4_kind <= s3_kind;
    s4_seg_miss <= seg_miss4;
    s4_circ_miss <= circ_miss4;
    s4_den <= $unsigned(den_a);
    s4_un <= un_n;
    s4_f2 <= s3_f2;
    s4_h <= roi_pkg::H_W'(hsum >>> roi_pkg::DIR_FRAC_BITS);
    s4_r2 <= s3_r2;
  end

  // stage 5
  always_ff @(posedge clk) begin
    s5_kind <= s4_kind;
    s5_seg_miss <= s4_seg_miss;
    s5_circ_miss <= s4_circ_miss;
    s5_dr <= roi_pkg::NUM_W'(s4_den) * roi_pkg::NUM_W'(max_range);
    s5_num <= roi_pkg::NUM_W'($unsigned(s4_un)) << roi_pkg::DIR_FRAC_BITS;
    s5_den <= s4_den;
    s5_hh <= roi_pkg::SQ_W'(s4_h) * roi_pkg::SQ_W'(s4_h);
    s5_rem <= (roi_pkg::W3 + 1)'(s4_f2) - $signed((roi_pkg::W3 + 1)'(s4_r2));
    s5_h <= s4_h;
  end

  // stage 6 logic: range test on the segment, discriminant sign on the circle
  always_comb begin
    q_full = $signed({1'b0, s5_hh}) - (roi_pkg::SQ_W + 1)'(s5_rem);
    seg_miss6 = s5_seg_miss || (s5_num > s5_dr);
    circ_miss6 = s5_circ_miss || (q_full < 0);
  end

  always_ff @(posedge clk) begin
    job.kind <= s5_kind;
    job.miss <= (s5_kind == roi_pkg::KIND_CIRCLE) ? circ_miss6 : seg_miss6;
    job.num <= s5_num;
    job.den <= s5_den;
    job.q <= q_full[roi_pkg::SQ_W-1:0];
    job.h <= s5_h;
  end

endmodule

// ----- sv/roi_queue.sv -----
// roi_queue: short job queue between the front and the back
// depends on roi_pkg
module roi_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  roi_pkg::job_t     wr_job,
  input  logic              rd,
  output roi_pkg::job_t     head,
  output roi_pkg::q_stat_t  q_stat
);

  roi_pkg::job_t               mem [roi_pkg::JQ_DEPTH];
  logic [roi_pkg::JQ_AW-1:0]   wr_ptr, rd_ptr;
  logic [roi_pkg::JQ_CW-1:0]   count;

  assign head = mem[rd_ptr];
  assign q_stat.count = count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      count <= count + roi_pkg::JQ_CW'(wr) - roi_pkg::JQ_CW'(rd);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_job;
  end

endmodule

// ----- sv/roi_back.sv -----
// roi_back: shared restoring divide and digit square root pipeline, root select, result queue
// depends on roi_pkg
module roi_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [roi_pkg::DIST_W-1:0]  max_range,
  input  roi_pkg::q_stat_t            q_stat,
  input  roi_pkg::job_t               head,
  output logic                        job_pop,
  input  logic                        pop,
  output logic                        empty,
  output logic [roi_pkg::DIST_W-1:0]  distance,
  output logic                        hit,
  output roi_pkg::b_stat_t            b_stat
);

  roi_pkg::stage_t                src [roi_pkg::B_STAGES];
  roi_pkg::stage_t                nx  [roi_pkg::B_STAGES];
  roi_pkg::stage_t                st  [roi_pkg::B_STAGES];
  logic                           st_valid [roi_pkg::B_STAGES];
  logic [roi_pkg::NUM_W-1:0]      d_num [roi_pkg::B_STAGES];
  logic [roi_pkg::DIV_STEPS-1:0]  d_quo [roi_pkg::B_STAGES];
  logic [roi_pkg::SQ_W-1:0]       r_v   [roi_pkg::B_STAGES];
  logic [roi_pkg::SQ_W-1:0]       r_res [roi_pkg::B_STAGES];
  roi_pkg::stage_t                init;
  roi_pkg::stage_t                last;

  logic [roi_pkg::BC_W-1:0]       bcnt;
  logic [roi_pkg::OQ_SW-1:0]      reserve;
  logic                           out_wr, out_rd;
  logic [roi_pkg::OQ_AW-1:0]      oq_wr_ptr, oq_rd_ptr;
  logic [roi_pkg::OQ_CW-1:0]      oq_count;
  logic [roi_pkg::DIST_W:0]       oq_mem [roi_pkg::OQ_DEPTH];

  logic [roi_pkg::H_W-1:0]        root;
  logic signed [roi_pkg::T_W-1:0] t1, t2;
  logic signed [roi_pkg::T_W-1:0] range_s;
  logic                           t1_ok, t2_ok;
  logic [roi_pkg::DIST_W-1:0]     res_dist;
  logic                           res_hit;

  // take a job only when the result queue can hold everything in flight
  assign reserve = roi_pkg::OQ_SW'(oq_count) + roi_pkg::OQ_SW'(bcnt);
  assign job_pop = (q_stat.count != '0) &&
                   (reserve < roi_pkg::OQ_SW'(roi_pkg::OQ_DEPTH));

  // job enters the pipeline
  always_comb begin
    init.kind = head.kind;
    init.miss = head.miss;
    init.num = head.num;
    init.den = head.den;
    init.quo = '0;
    init.v = head.q;
    init.res = '0;
    init.h = head.h;
  end

  for (genvar k = 0; k < roi_pkg::B_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign src[k] = init;
    end else begin : g_next
      assign src[k] = st[k-1];
    end

    // one quotient bit per stage
    if (k < roi_pkg::DIV_STEPS) begin : g_div
      localparam int SH = roi_pkg::DIV_STEPS - 1 - k;
      logic [roi_pkg::NUM_W-1:0] dsub;
      assign dsub = roi_pkg::NUM_W'(src[k].den) << SH;
      always_comb begin
        d_num[k] = src[k].num;
        d_quo[k] = src[k].quo;
        if (src[k].num >= dsub) begin
          d_num[k] = src[k].num - dsub;
          d_quo[k][SH] = 1'b1;
        end
      end
    end else begin : g_nodiv
      assign d_num[k] = src[k].num;
      assign d_quo[k] = src[k].quo;
    end

    // one root bit per stage
    if (k < roi_pkg::ROOT_STEPS) begin : g_sqrt
      localparam int BP = roi_pkg::SQ_W - 2 - 2 * k;
      localparam logic [roi_pkg::SQ_W-1:0] BITV = roi_pkg::SQ_W'(1) << BP;
      logic [roi_pkg::SQ_W:0] trial;
      assign trial = (roi_pkg::SQ_W + 1)'(src[k].res) + (roi_pkg::SQ_W + 1)'(BITV);
      always_comb begin
        if ({1'b0, src[k].v} >= trial) begin
          r_v[k] = src[k].v - trial[roi_pkg::SQ_W-1:0];
          r_res[k] = (src[k].res >> 1) + BITV;
        end else begin
          r_v[k] = src[k].v;
          r_res[k] = src[k].res >> 1;
        end
      end
    end else begin : g_nosqrt
      assign r_v[k] = src[k].v;
      assign r_res[k] = src[k].res;
    end

    always_comb begin
      nx[k] = src[k];
      nx[k].num = d_num[k];
      nx[k].quo = d_quo[k];
      nx[k].v = r_v[k];
      nx[k].res = r_res[k];
    end

    always_ff @(posedge clk) begin
      st[k] <= nx[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (k == 0) begin
        st_valid[k] <= job_pop;
      end else begin
        st_valid[k] <= st_valid[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // pick the nearer root in range, or the quotient for a segment
  assign last = st[roi_pkg::B_STAGES-1];
  always_comb begin
    root = last.res[roi_pkg::H_W-1:0];
    range_s = $signed(roi_pkg::T_W'(max_range));
    t1 = -roi_pkg::T_W'(last.h) - $signed(roi_pkg::T_W'(root));
    t2 = -roi_pkg::T_W'(last.h) + $signed(roi_pkg::T_W'(root));
    t1_ok = (t1 >= 0) && (t1 <= range_s);
    t2_ok = (t2 >= 0) && (t2 <= range_s);
    res_dist = max_range;
    res_hit = 1'b0;
    if (!last.miss) begin
      if (last.kind == roi_pkg::KIND_SEGMENT) begin
        res_dist = last.quo;
        res_hit = 1'b1;
      end else if (t1_ok) begin
        res_dist = t1[roi_pkg::DIST_W-1:0];
        res_hit = 1'b1;
      end else if (t2_ok) begin
        res_dist = t2[roi_pkg::DIST_W-1:0];
        res_hit = 1'b1;
      end
    end
  end

  assign out_wr = st_valid[roi_pkg::B_STAGES-1];
  assign out_rd = pop && !empty;

  // in-flight count and result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      bcnt <= '0;
      oq_wr_ptr <= '0;
      oq_rd_ptr <= '0;
      oq_count <= '0;
    end else begin
      bcnt <= bcnt + roi_pkg::BC_W'(job_pop) - roi_pkg::BC_W'(out_wr);
      if (out_wr) oq_wr_ptr <= oq_wr_ptr + 1'b1;
      if (out_rd) oq_rd_ptr <= oq_rd_ptr + 1'b1;
      oq_count <= oq_count + roi_pkg::OQ_CW'(out_wr) - roi_pkg::OQ_CW'(out_rd);
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (out_wr) oq_mem[oq_wr_ptr] <= {res_dist, res_hit};
  end

  assign empty = (oq_count == '0);
  assign distance = oq_mem[oq_rd_ptr][roi_pkg::DIST_W:1];
  assign hit = oq_mem[oq_rd_ptr][0];
  assign b_stat.inflight = bcnt;
  assign b_stat.out_count = oq_count;

endmodule

// ----- sv/ray_obstacle_intersection.sv -----
// ray_obstacle_intersection: top level, range register, front, job queue and back
// depends on roi_pkg, roi_front, roi_queue, roi_back
//
//  channel  | handshake        | words
//  ---------+------------------+---------------------------------------------
//  input    | push / full      | kind, ray, direction, points a and b, radius
//  result   | pop / empty      | distance, hit
//  config   | cfg_write        | cfg_data -> max_range
//
// one word per cycle while full is low; a word passes six front stages, the job queue,
// one stage per root bit (21) in the shared divide/root pipeline, then the result queue.
// full rises when queued jobs plus front words in flight reach the 16-entry job queue.
// the back takes a job only when the 32-entry result queue can hold all it has in flight.
// reset clears pointers and counters and loads max_range with 51200; no clearing pass.
module ray_obstacle_intersection (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        kind,
  input  logic signed [15:0]          ray_x,
  input  logic signed [15:0]          ray_y,
  input  logic signed [15:0]          dir_cos,
  input  logic signed [15:0]          dir_sin,
  input  logic signed [15:0]          point_a_x,
  input  logic signed [15:0]          point_a_y,
  input  logic signed [15:0]          point_b_x,
  input  logic signed [15:0]          point_b_y,
  input  logic [14:0]                 radius,
  output logic                        empty,
  input  logic                        pop,
  output logic [roi_pkg::DIST_W-1:0]  distance,
  output logic                        hit,
  input  logic                        cfg_write,
  input  logic [roi_pkg::DIST_W-1:0]  cfg_data
);

  logic [roi_pkg::DIST_W-1:0]  max_range;
  roi_pkg::q_stat_t            q_stat;
  roi_pkg::b_stat_t            b_stat;
  roi_pkg::job_t               job, head;
  logic                        job_valid, job_pop;
  logic [roi_pkg::FC_W-1:0]    f_inflight;
  logic [roi_pkg::JQ_SW-1:0]   jq_total;
  logic [roi_pkg::OQ_SW-1:0]   oq_total;

  // range register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_range <= roi_pkg::RANGE_RESET;
    end else if (cfg_write) begin
      max_range <= cfg_data;
    end
  end

  roi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .ray_x     (ray_x),
    .ray_y     (ray_y),
    .dir_cos   (dir_cos),
    .dir_sin   (dir_sin),
    .point_a_x (point_a_x),
    .point_a_y (point_a_y),
    .point_b_x (point_b_x),
    .point_b_y (point_b_y),
    .radius    (radius),
    .max_range (max_range),
    .q_stat    (q_stat),
    .job_valid (job_valid),
    .job       (job),
    .inflight  (f_inflight)
  );

  roi_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_valid),
    .wr_job (job),
    .rd     (job_pop),
    .head   (head),
    .q_stat (q_stat)
  );

  roi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .max_range (max_range),
    .q_stat    (q_stat),
    .head      (head),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .distance  (distance),
    .hit       (hit),
    .b_stat    (b_stat)
  );

  // credit totals on both queues
  assign jq_total = roi_pkg::JQ_SW'(q_stat.count) + roi_pkg::JQ_SW'(f_inflight);
  assign oq_total = roi_pkg::OQ_SW'(b_stat.out_count) + roi_pkg::OQ_SW'(b_stat.inflight);

  // job queue never holds more than its credit allows
  a_jq_credit: assert property (@(posedge clk) disable iff (rst)
    jq_total <= roi_pkg::JQ_SW'(roi_pkg::JQ_DEPTH))
    else $error("job queue credit exceeded");

  // result queue never overflows, counting results still in the back pipeline
  a_oq_credit: assert property (@(posedge clk) disable iff (rst)
    oq_total <= roi_pkg::OQ_SW'(roi_pkg::OQ_DEPTH))
    else $error("result queue credit exceeded");

  // a job can only leave the queue when one is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> (q_stat.count != '0))
    else $error("job popped from empty queue");

  // after reset nothing is waiting and input is open
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("block not idle after reset");

endmodule
